// File: sv/htd_pkg.sv
// Package: shared types and constants of the preorder-tree decoder.
`default_nettype none
package htd_pkg;
  localparam int MaxLeaves = 256;
  localparam int MaxNodes  = 2 * MaxLeaves - 1;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int LeafW     = $clog2(MaxLeaves);
  localparam int CntW      = $clog2(MaxLeaves + 1);
  localparam int NodeCntW  = $clog2(MaxNodes + 1);
  localparam int CharW     = 8;
  localparam int QDepth    = 2;

  typedef enum logic [1:0] {
    REQ_STRUCT = 2'd0,
    REQ_CHAR   = 2'd1,
    REQ_BIT    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MALFORM  = 2'd1,
    ST_NOT_DONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_LEAF = 2'd2,
    B_CHAR = 2'd3
  } back_state_t;

  // node children
  typedef struct packed {
    logic [NodeW-1:0] left;
    logic [NodeW-1:0] right;
  } node_t;

  // leaf flag and leaf index of a node
  typedef struct packed {
    logic             leaf;
    logic [LeafW-1:0] lidx;
  } linfo_t;

  // request moved from the front part to the back part
  typedef struct packed {
    logic             walk;
    logic             clr;
    logic             bit_value;
    status_t          status;
  } cmd_t;
endpackage
`default_nettype wire

// File: sv/htd_if.sv
// Interfaces: request channel and result channel.
`default_nettype none
interface htd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       bit_value;
  logic [7:0] char_value;
  modport source (output valid, req_type, bit_value, char_value, input ready);
  modport sink (input valid, req_type, bit_value, char_value, output ready);
endinterface

interface htd_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] decoded_char;
  logic [1:0] status;
  modport source (output valid, char_valid, decoded_char, status, input ready);
  modport sink (input valid, char_valid, decoded_char, status, output ready);
endinterface
`default_nettype wire

// File: sv/htd_ram.sv
// Generic single-port-write, one-read RAM with registered read.
`default_nettype none
module htd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/htd_front.sv
// Front part: tree building, counters, request classification.
`default_nettype none
module htd_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  htd_in_if.sink                      in_ch,
  input  wire logic                   q_full,
  input  wire logic                   back_busy,
  output logic                        q_push,
  output htd_pkg::cmd_t               q_cmd,
  output logic                        root_leaf,
  output logic                        nd_we,
  output logic [htd_pkg::NodeW-1:0]   nd_waddr,
  output htd_pkg::node_t              nd_wdata,
  output logic                        li_we,
  output logic [htd_pkg::NodeW-1:0]   li_waddr,
  output htd_pkg::linfo_t             li_wdata,
  output logic                        ch_we,
  output logic [htd_pkg::LeafW-1:0]   ch_waddr,
  output logic [htd_pkg::CharW-1:0]   ch_wdata
);
  import htd_pkg::*;

  // Children of a node are written once its right child is known; the left
  // child of an internal node is always n+1. Leaf flag and index go to the
  // leaf map as each node is created.
  logic [NodeCntW-1:0] nodes_r, nodes_nxt;
  logic [CntW-1:0]     leaves_r, leaves_nxt;
  logic [CntW-1:0]     chars_r, chars_nxt;
  logic [LeafW-1:0]    sdepth_r, sdepth_nxt;
  logic                done_r, done_nxt;
  logic                rootleaf_r, rootleaf_nxt;
  logic                prevleaf_r, prevleaf_nxt;
  logic                stk_we;
  logic [LeafW-1:0]    stk_addr;
  logic [LeafW-1:0]    stk_raddr;
  logic [NodeW-1:0]    stk_rdata;
  logic [NodeW-1:0]    stk_top;
  logic                stk_fwd_r;
  logic [NodeW-1:0]    stk_fwd_d_r;
  logic                acc;
  req_t                req;
  logic                is_leaf_bit;
  logic [NodeW-1:0]    n;

  // Stack as a RAM; top is read ahead at depth-1, a word just pushed is
  // forwarded since the read sees the old contents.
  assign stk_raddr = sdepth_nxt - LeafW'(1);
  htd_ram #(.Width(NodeW), .Depth(MaxLeaves)) u_stk (
    .clk, .we(stk_we), .waddr(stk_addr), .wdata(n),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );
  assign stk_top = stk_fwd_r ? stk_fwd_d_r : stk_rdata;

  assign req         = req_t'(in_ch.req_type);
  assign is_leaf_bit = in_ch.bit_value;
  assign n           = nodes_r[NodeW-1:0];
  // walk requests read the node memories; hold structure while back is busy
  assign in_ch.ready = !q_full && !(req == REQ_STRUCT && back_busy);
  assign acc         = in_ch.valid && in_ch.ready;
  assign q_push      = acc;
  assign root_leaf   = rootleaf_r;
  assign ch_wdata    = in_ch.char_value;
  assign ch_waddr    = chars_r[LeafW-1:0];
  assign li_waddr    = n;

  always_comb begin
    nodes_nxt    = nodes_r;
    leaves_nxt   = leaves_r;
    chars_nxt    = chars_r;
    sdepth_nxt   = sdepth_r;
    done_nxt     = done_r;
    rootleaf_nxt = rootleaf_r;
    prevleaf_nxt = prevleaf_r;
    stk_we       = 1'b0;
    stk_addr     = sdepth_r;
    nd_we        = 1'b0;
    nd_waddr     = n;
    nd_wdata     = '0;
    li_we        = 1'b0;
    li_wdata     = '0;
    ch_we        = 1'b0;
    q_cmd        = '{walk: 1'b0, clr: 1'b0, bit_value: in_ch.bit_value, status: ST_OK};
    if (acc) begin
      case (req)
        REQ_STRUCT: begin
          if (done_r || nodes_r >= NodeCntW'(MaxNodes) ||
              (is_leaf_bit && leaves_r >= CntW'(MaxLeaves)) ||
              (!is_leaf_bit && sdepth_r >= LeafW'(MaxLeaves - 1))) begin
            q_cmd.status = ST_MALFORM;
          end else begin
            li_we         = 1'b1;
            li_wdata.leaf = is_leaf_bit;
            li_wdata.lidx = is_leaf_bit ? leaves_r[LeafW-1:0] : '0;
            if (nodes_r != '0 && prevleaf_r) begin
              // pop parent, complete its record
              sdepth_nxt     = sdepth_r - LeafW'(1);
              nd_we          = 1'b1;
              nd_waddr       = stk_top;
              nd_wdata.left  = stk_top + NodeW'(1);
              nd_wdata.right = n;
            end
            if (is_leaf_bit) begin
              if (sdepth_nxt == '0) done_nxt = 1'b1;
              leaves_nxt = leaves_r + CntW'(1);
            end else begin
              stk_we     = 1'b1;
              stk_addr   = sdepth_nxt;
              sdepth_nxt = sdepth_nxt + LeafW'(1);
            end
            if (nodes_r == '0) rootleaf_nxt = is_leaf_bit;
            prevleaf_nxt = is_leaf_bit;
            nodes_nxt    = nodes_r + NodeCntW'(1);
          end
        end
        REQ_CHAR: begin
          if (!done_r) q_cmd.status = ST_NOT_DONE;
          else if (chars_r >= leaves_r) q_cmd.status = ST_MALFORM;
          else begin
            ch_we     = 1'b1;
            chars_nxt = chars_r + CntW'(1);
          end
        end
        REQ_BIT: begin
          if (!done_r || chars_r != leaves_r) q_cmd.status = ST_NOT_DONE;
          else q_cmd.walk = 1'b1;
        end
        default: begin
          q_cmd.clr  = 1'b1;
          nodes_nxt  = '0;
          leaves_nxt = '0;
          chars_nxt  = '0;
          sdepth_nxt = '0;
          done_nxt   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r    <= '0;
      leaves_r   <= '0;
      chars_r    <= '0;
      sdepth_r   <= '0;
      done_r     <= 1'b0;
      rootleaf_r <= 1'b0;
      prevleaf_r <= 1'b0;
      stk_fwd_r  <= 1'b0;
    end else begin
      nodes_r    <= nodes_nxt;
      leaves_r   <= leaves_nxt;
      chars_r    <= chars_nxt;
      sdepth_r   <= sdepth_nxt;
      done_r     <= done_nxt;
      rootleaf_r <= rootleaf_nxt;
      prevleaf_r <= prevleaf_nxt;
      stk_fwd_r  <= stk_we;
    end
    if (stk_we) stk_fwd_d_r <= n;
  end
endmodule
`default_nettype wire

// File: sv/htd_leafmap.sv
// Leaf map: per-node leaf flag and leaf index, written as each node is created.
`default_nettype none
module htd_leafmap (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [htd_pkg::NodeW-1:0] waddr,
  input  wire htd_pkg::linfo_t           wdata,
  input  wire logic [htd_pkg::NodeW-1:0] raddr,
  output htd_pkg::linfo_t                rdata
);
  import htd_pkg::*;

  htd_ram #(.Width($bits(linfo_t)), .Depth(MaxNodes)) u_info (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
endmodule
`default_nettype wire

// File: sv/htd_back.sv
// Back part: tree walk through the node RAM and result register.
`default_nettype none
module htd_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire htd_pkg::cmd_t          q_cmd,
  output logic                        q_pop,
  output logic                        busy,
  input  wire logic                   root_leaf,
  output logic [htd_pkg::NodeW-1:0]   nd_raddr,
  input  wire htd_pkg::node_t         nd_rdata,
  input  wire htd_pkg::linfo_t        li_rdata,
  output logic [htd_pkg::LeafW-1:0]   ch_raddr,
  input  wire logic [htd_pkg::CharW-1:0] ch_rdata,
  htd_out_if.source                   out_ch
);
  import htd_pkg::*;

  back_state_t      st_r, st_nxt;
  logic [NodeW-1:0] cur_r, cur_nxt;
  logic             bit_r, bit_nxt;
  logic             ov_r, ov_nxt;
  logic             oc_r, oc_nxt;
  logic [1:0]       os_r, os_nxt;
  logic [CharW-1:0] od_r, od_nxt;
  logic             take;

  assign take         = !ov_r || out_ch.ready;
  assign busy         = st_r != B_IDLE || q_valid;
  assign out_ch.valid = ov_r;
  assign out_ch.char_valid   = oc_r;
  assign out_ch.decoded_char = od_r;
  assign out_ch.status       = os_r;

  // walk: pop reads current node, B_READ reads the child, B_LEAF reads the
  // child's character, B_CHAR loads the result
  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    bit_nxt  = bit_r;
    ov_nxt   = ov_r && !out_ch.ready;
    oc_nxt   = oc_r;
    os_nxt   = os_r;
    od_nxt   = od_r;
    q_pop    = 1'b0;
    nd_raddr = cur_r;
    ch_raddr = li_rdata.lidx;
    case (st_r)
      B_IDLE: begin
        if (q_valid && take) begin
          q_pop = 1'b1;
          if (!q_cmd.walk) begin
            ov_nxt = 1'b1; oc_nxt = 1'b0; od_nxt = '0; os_nxt = q_cmd.status;
            if (q_cmd.clr) cur_nxt = '0;
          end else begin
            bit_nxt = q_cmd.bit_value;
            st_nxt  = B_READ;
          end
        end
      end
      B_READ: begin
        if (root_leaf) nd_raddr = '0;
        else nd_raddr = bit_r ? nd_rdata.right : nd_rdata.left;
        cur_nxt = nd_raddr;
        st_nxt  = B_LEAF;
      end
      B_LEAF: st_nxt = B_CHAR;
      B_CHAR: begin
        if (take) begin
          ov_nxt = 1'b1;
          oc_nxt = li_rdata.leaf;
          od_nxt = li_rdata.leaf ? ch_rdata : '0;
          os_nxt = ST_OK;
          if (li_rdata.leaf) cur_nxt = '0;
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      cur_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cur_r <= cur_nxt;
      ov_r  <= ov_nxt;
    end
    bit_r <= bit_nxt;
    oc_r  <= oc_nxt;
    os_r  <= os_nxt;
    od_r  <= od_nxt;
  end
endmodule
`default_nettype wire

// File: sv/huffman_tree_decoder_core.sv
// Top level: preorder-loaded code tree decoder.
// Requests enter a front part that builds the tree and classifies every
// request; a two-entry queue passes them to a back part that answers them
// in order, one result per request. Structure, character and clear requests
// are answered straight from the queue pop. An encoded bit goes through the
// registered read of the current node, the registered read of the chosen
// child, the registered read of that child's character, and the result
// register. A result waiting at the output holds the back part. Structure
// requests wait while any request is queued or in the back part.
`default_nettype none
module huffman_tree_decoder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  htd_in_if.sink    in_ch,
  htd_out_if.source out_ch
);
  import htd_pkg::*;

  cmd_t             q_mem_r [QDepth];
  logic [0:0]       q_wp_r, q_rp_r;
  logic [1:0]       q_cnt_r;
  logic             q_push, q_pop, q_full, busy, root_leaf;
  cmd_t             q_cmd_in;
  logic             nd_we, li_we, ch_we;
  logic [NodeW-1:0] nd_waddr, nd_raddr, li_waddr;
  node_t            nd_wdata, nd_rdata;
  linfo_t           li_wdata, li_rdata;
  logic [LeafW-1:0] ch_waddr, ch_raddr;
  logic [CharW-1:0] ch_wdata, ch_rdata;

  assign q_full = q_cnt_r == 2'(QDepth);

  htd_front u_front (
    .clk, .rst_n, .in_ch, .q_full, .back_busy(busy), .q_push, .q_cmd(q_cmd_in),
    .root_leaf, .nd_we, .nd_waddr, .nd_wdata, .li_we, .li_waddr, .li_wdata,
    .ch_we, .ch_waddr, .ch_wdata
  );

  htd_ram #(.Width($bits(node_t)), .Depth(MaxNodes)) u_nodes (
    .clk, .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  htd_leafmap u_leaves (
    .clk, .we(li_we), .waddr(li_waddr), .wdata(li_wdata),
    .raddr(nd_raddr), .rdata(li_rdata)
  );

  htd_ram #(.Width(CharW), .Depth(MaxLeaves)) u_chars (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  htd_back u_back (
    .clk, .rst_n, .q_valid(q_cnt_r != '0), .q_cmd(q_mem_r[q_rp_r]), .q_pop,
    .busy, .root_leaf, .nd_raddr, .nd_rdata, .li_rdata, .ch_raddr, .ch_rdata,
    .out_ch
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) q_wp_r <= q_wp_r + 1'b1;
      if (q_pop)  q_rp_r <= q_rp_r + 1'b1;
      q_cnt_r <= q_cnt_r + 2'(q_push) - 2'(q_pop);
    end
    if (q_push) q_mem_r[q_wp_r] <= q_cmd_in;
  end

  a_q_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r == 2'(QDepth) |-> !q_push || q_pop) else $error("queue overflow");
  a_q_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_cnt_r != '0) else $error("queue underflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
endmodule
`default_nettype wire
